// ===== rtl/scp_pkg.sv =====
// Shared types and constants for the serial command parser.
// Used by every module under rtl/; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package scp_pkg;

  localparam int MaxValuesDef = 32;
  localparam int TextBytesDef = 32;

  localparam int CountW     = 7;
  localparam int StoreAddrW = 6;
  localparam int CfgIndexW  = 2;
  localparam int CfgDataW   = 64;
  localparam int OutDataW   = 64;

  typedef enum logic [CfgIndexW-1:0] {
    CFG_VALUE_LOW  = 2'd0,
    CFG_VALUE_HIGH = 2'd1,
    CFG_PLAIN_LOW  = 2'd2,
    CFG_PLAIN_HIGH = 2'd3
  } cfg_index_e;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_SCALAR = 2'd1,
    KIND_VECTOR = 2'd2,
    KIND_TEXT   = 2'd3
  } payload_kind_e;

  typedef enum logic [3:0] {
    PH_OPCODE       = 4'd0,
    PH_PAYLOAD      = 4'd1,
    PH_VEC_START    = 4'd3,
    PH_SCALAR_DIGIT = 4'd4,
    PH_VEC_DIGIT    = 4'd5,
    PH_SCALAR_MORE  = 4'd6,
    PH_VEC_MORE     = 4'd7,
    PH_SEPARATOR    = 4'd8,
    PH_TEXT         = 4'd9
  } phase_e;

  localparam logic [7:0] ChMinus  = 8'h2D;
  localparam logic [7:0] ChOpen   = 8'h5B;
  localparam logic [7:0] ChClose  = 8'h5D;
  localparam logic [7:0] ChComma  = 8'h2C;
  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;

  typedef struct packed {
    logic [7:0]        opcode;
    payload_kind_e     kind;
    logic [CountW-1:0] count;
    logic [31:0]       number;
  } cmd_desc_t;

  typedef struct packed {
    logic                  v_we;
    logic [StoreAddrW-1:0] v_addr;
    logic [31:0]           v_data;
    logic                  t_we;
    logic [StoreAddrW-1:0] t_addr;
    logic [7:0]            t_data;
  } store_wr_t;

endpackage

`default_nettype wire

// ===== rtl/scp_front.sv =====
// Byte classifier and grammar FSM; holds the opcode maps.
// Emits store writes and command descriptors. Depends on scp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module scp_front #(
  parameter int MAX_VALUES = scp_pkg::MaxValuesDef,
  parameter int TEXT_BYTES = scp_pkg::TextBytesDef
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [scp_pkg::CfgIndexW-1:0]  cfg_index_i,
  input  wire logic [scp_pkg::CfgDataW-1:0]   cfg_data_i,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [7:0]                     in_byte_i,
  input  wire logic                           queue_full_i,
  input  wire logic                           store_busy_i,
  output logic                                push_o,
  output scp_pkg::cmd_desc_t                  desc_o,
  output scp_pkg::store_wr_t                  wr_o
);
  import scp_pkg::*;

  localparam int VCW = $clog2(MAX_VALUES + 1);
  localparam int TCW = $clog2(TEXT_BYTES);

  logic [127:0]   vmap_q, pmap_q;
  phase_e         phase_q, phase_d;
  logic [7:0]     opcode_q, opcode_d;
  logic           neg_q, neg_d;
  logic [31:0]    acc_q, acc_d;
  logic [VCW-1:0] vcnt_q, vcnt_d;
  logic [TCW-1:0] tcnt_q, tcnt_d;

  logic fire, is_dig, is_sep, in_vmap, in_pmap, v_room, t_room;
  logic [31:0]    dval;
  logic [VCW-1:0] vcnt_push;

  function automatic logic [31:0] add_digit(input logic [31:0] acc, input logic [7:0] b,
                                            input logic neg);
    logic [31:0] d, m;
    d = {28'd0, b[3:0] - ChZero[3:0]};
    m = (acc << 3) + (acc << 1);
    return neg ? m - d : m + d;
  endfunction

  assign in_ready_o = !queue_full_i &&
                      !(store_busy_i && (phase_q == PH_VEC_MORE || phase_q == PH_TEXT));
  assign fire    = in_valid_i && in_ready_o;
  assign is_dig  = (in_byte_i >= ChZero) && (in_byte_i <= ChNine);
  assign is_sep  = (in_byte_i == ChSpace) || (in_byte_i == ChLf) || (in_byte_i == ChCr);
  assign in_vmap = !in_byte_i[7] && vmap_q[in_byte_i[6:0]];
  assign in_pmap = !in_byte_i[7] && pmap_q[in_byte_i[6:0]];
  assign dval    = {28'd0, in_byte_i[3:0] - ChZero[3:0]};
  assign v_room  = vcnt_q < VCW'(MAX_VALUES);
  assign t_room  = tcnt_q < TCW'(TEXT_BYTES - 1);
  assign vcnt_push = v_room ? vcnt_q + VCW'(1) : vcnt_q;

  always_comb begin
    phase_d  = phase_q;
    opcode_d = opcode_q;
    neg_d    = neg_q;
    acc_d    = acc_q;
    vcnt_d   = vcnt_q;
    tcnt_d   = tcnt_q;
    push_o   = 1'b0;
    desc_o   = '{opcode: opcode_q, kind: KIND_NONE, count: '0, number: '0};
    wr_o     = '{v_we: 1'b0, v_addr: StoreAddrW'(vcnt_q), v_data: acc_q,
                 t_we: 1'b0, t_addr: StoreAddrW'(tcnt_q), t_data: in_byte_i};
    if (fire) begin
      phase_d = PH_OPCODE;
      case (phase_q)
        PH_OPCODE: begin
          if (in_vmap || in_pmap) begin
            opcode_d = in_byte_i;
            vcnt_d   = '0;
            tcnt_d   = '0;
            phase_d  = in_vmap ? PH_PAYLOAD : PH_SEPARATOR;
          end
        end
        PH_SEPARATOR: begin
          if (is_sep) begin
            push_o = 1'b1;
          end
        end
        PH_PAYLOAD: begin
          if (in_byte_i == ChOpen) begin
            acc_d   = '0;
            neg_d   = 1'b1;
            phase_d = PH_VEC_START;
          end else if (in_byte_i == ChMinus) begin
            acc_d   = '0;
            neg_d   = 1'b1;
            phase_d = PH_SCALAR_DIGIT;
          end else if (is_dig) begin
            acc_d   = dval;
            neg_d   = 1'b0;
            phase_d = PH_SCALAR_MORE;
          end else if (in_byte_i == ChQuote) begin
            tcnt_d  = '0;
            phase_d = PH_TEXT;
          end
        end
        PH_SCALAR_DIGIT, PH_VEC_DIGIT: begin
          if (is_dig) begin
            acc_d   = add_digit('0, in_byte_i, neg_q);
            phase_d = (phase_q == PH_SCALAR_DIGIT) ? PH_SCALAR_MORE : PH_VEC_MORE;
          end
        end
        PH_SCALAR_MORE: begin
          if (is_dig) begin
            acc_d   = add_digit(acc_q, in_byte_i, neg_q);
            phase_d = PH_SCALAR_MORE;
          end else if (is_sep) begin
            vcnt_d = VCW'(1);
            push_o = 1'b1;
            desc_o = '{opcode: opcode_q, kind: KIND_SCALAR, count: CountW'(1), number: acc_q};
          end
        end
        PH_VEC_START: begin
          if (in_byte_i == ChMinus) begin
            acc_d   = '0;
            neg_d   = 1'b1;
            phase_d = PH_VEC_DIGIT;
          end else if (is_dig) begin
            acc_d   = dval;
            neg_d   = 1'b0;
            phase_d = PH_VEC_MORE;
          end
        end
        PH_VEC_MORE: begin
          if (is_dig) begin
            acc_d   = add_digit(acc_q, in_byte_i, neg_q);
            phase_d = PH_VEC_MORE;
          end else if (in_byte_i == ChComma || in_byte_i == ChClose) begin
            wr_o.v_we = v_room;
            vcnt_d    = vcnt_push;
            if (in_byte_i == ChComma) begin
              phase_d = PH_VEC_START;
            end else begin
              push_o = 1'b1;
              desc_o = '{opcode: opcode_q, kind: KIND_VECTOR,
                         count: CountW'(vcnt_push), number: '0};
            end
          end
        end
        PH_TEXT: begin
          if (in_byte_i == ChQuote) begin
            push_o = 1'b1;
            desc_o = '{opcode: opcode_q, kind: KIND_TEXT,
                       count: CountW'(tcnt_q), number: '0};
          end else begin
            phase_d = PH_TEXT;
            if (t_room) begin
              wr_o.t_we = 1'b1;
              tcnt_d    = tcnt_q + TCW'(1);
            end
          end
        end
        default: phase_d = PH_OPCODE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_OPCODE;
      opcode_q <= '0;
      neg_q    <= 1'b0;
      acc_q    <= '0;
      vcnt_q   <= '0;
      tcnt_q   <= '0;
    end else begin
      phase_q  <= phase_d;
      opcode_q <= opcode_d;
      neg_q    <= neg_d;
      acc_q    <= acc_d;
      vcnt_q   <= vcnt_d;
      tcnt_q   <= tcnt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vmap_q <= 128'd1;
      pmap_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_e'(cfg_index_i))
        CFG_VALUE_LOW:  vmap_q[63:0]   <= cfg_data_i;
        CFG_VALUE_HIGH: vmap_q[127:64] <= cfg_data_i;
        CFG_PLAIN_LOW:  pmap_q[63:0]   <= cfg_data_i;
        CFG_PLAIN_HIGH: pmap_q[127:64] <= cfg_data_i;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/scp_queue.sv =====
// Two-entry command descriptor queue between front and back.
// Depends on scp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module scp_queue (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  scp_pkg::cmd_desc_t desc_i,
  output logic              full_o,
  output logic              valid_o,
  input  wire logic         pop_i,
  output scp_pkg::cmd_desc_t desc_o
);
  import scp_pkg::*;

  cmd_desc_t  slot_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign desc_o  = slot_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wp_q] <= desc_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= !wp_q;
      if (pop_i)  rp_q <= !rp_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/scp_back.sv =====
// Value and text stores plus the result run sequencer with output register.
// Depends on scp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module scp_back #(
  parameter int MAX_VALUES = scp_pkg::MaxValuesDef,
  parameter int TEXT_BYTES = scp_pkg::TextBytesDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  scp_pkg::store_wr_t                wr_i,
  input  wire logic                         cmd_valid_i,
  input  scp_pkg::cmd_desc_t                cmd_i,
  output logic                              pop_o,
  output logic                              busy_o,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [scp_pkg::OutDataW-1:0]      out_data_o,
  output logic [1:0]                        out_kind_o,
  output logic                              out_last_o
);
  import scp_pkg::*;

  localparam int TD  = TEXT_BYTES - 1;
  localparam int VAW = (MAX_VALUES > 1) ? $clog2(MAX_VALUES) : 1;
  localparam int TAW = (TD > 1) ? $clog2(TD) : 1;

  logic [31:0] vmem [MAX_VALUES];
  logic [7:0]  tmem [TD];

  logic              active_q;
  cmd_desc_t         cur_q;
  logic [CountW-1:0] idx_q;
  logic              ovalid_q, olast_q;
  cmd_desc_t         out_q;
  logic [4:0]        oidx_q;
  logic [31:0]       vrd_q;
  logic [7:0]        trd_q;

  logic              issue, fin;
  logic [CountW-1:0] nbeats;
  logic [31:0]       num;
  logic [7:0]        ch;

  assign nbeats = (cur_q.count == '0) ? CountW'(1) : cur_q.count;
  assign fin    = idx_q == nbeats - CountW'(1);
  assign issue  = active_q && (!ovalid_q || out_ready_i);
  assign pop_o  = !active_q && cmd_valid_i;
  assign busy_o = active_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.v_we) vmem[wr_i.v_addr[VAW-1:0]] <= wr_i.v_data;
    if (wr_i.t_we) tmem[wr_i.t_addr[TAW-1:0]] <= wr_i.t_data;
    if (issue) begin
      vrd_q <= vmem[idx_q[VAW-1:0]];
      trd_q <= tmem[idx_q[TAW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) cur_q <= cmd_i;
    if (issue) begin
      out_q   <= cur_q;
      oidx_q  <= (cur_q.count == '0) ? 5'd0 : idx_q[4:0];
      olast_q <= fin;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      idx_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        active_q <= 1'b1;
        idx_q    <= '0;
      end else if (issue) begin
        idx_q <= idx_q + CountW'(1);
        if (fin) active_q <= 1'b0;
      end
      if (issue) begin
        ovalid_q <= 1'b1;
      end else if (out_ready_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    case (out_q.kind)
      KIND_SCALAR: num = out_q.number;
      KIND_VECTOR: num = vrd_q;
      default:     num = '0;
    endcase
    ch = (out_q.kind == KIND_TEXT && out_q.count != '0) ? trd_q : 8'd0;
  end

  assign out_valid_o = ovalid_q;
  assign out_kind_o  = out_q.kind;
  assign out_last_o  = olast_q;
  assign out_data_o  = {5'd0, ch, num, oidx_q, out_q.count[5:0], out_q.opcode};

endmodule

`default_nettype wire

// ===== rtl/serial_command_parser.sv =====
// Serial command parser: takes one command byte per beat on the slave stream and
// emits one run of result beats per completed command on the master stream.
// While a command is parsed a byte is taken every cycle unless the queue is full
// or the body hold below applies. A finished command enters a two-entry queue;
// its run starts once it has passed the queue and the back's command register,
// moves one beat per cycle while the master stream is ready, paced by the store
// read and the output register, and ends before the next run starts. Bytes
// inside a vector or text body are held while an earlier run is still queued or
// being sent, since that run reads the value and text stores they would write.
// Depends on scp_pkg, scp_front, scp_queue and scp_back.
`timescale 1ns / 1ps
`default_nettype none

module serial_command_parser #(
  parameter int MAX_VALUES = scp_pkg::MaxValuesDef,
  parameter int TEXT_BYTES = scp_pkg::TextBytesDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [scp_pkg::CfgIndexW-1:0] cfg_index_i,
  input  wire logic [scp_pkg::CfgDataW-1:0]  cfg_data_i,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [7:0]                    s_axis_tdata,  // rx_byte
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // opcode[7:0] item_count[13:8] item_index[18:14] number[50:19] text_char[58:51]
  output logic [scp_pkg::OutDataW-1:0]       m_axis_tdata,
  output logic [1:0]                         m_axis_tuser,  // payload_kind
  output logic                               m_axis_tlast   // last
);
  import scp_pkg::*;

  logic      push, qfull, qvalid, pop, busy;
  cmd_desc_t desc_in, desc_out;
  store_wr_t wr;

  scp_front #(
    .MAX_VALUES(MAX_VALUES),
    .TEXT_BYTES(TEXT_BYTES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_byte_i    (s_axis_tdata),
    .queue_full_i (qfull),
    .store_busy_i (qvalid || busy),
    .push_o       (push),
    .desc_o       (desc_in),
    .wr_o         (wr)
  );

  scp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .desc_i  (desc_in),
    .full_o  (qfull),
    .valid_o (qvalid),
    .pop_i   (pop),
    .desc_o  (desc_out)
  );

  scp_back #(
    .MAX_VALUES(MAX_VALUES),
    .TEXT_BYTES(TEXT_BYTES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_i        (wr),
    .cmd_valid_i (qvalid),
    .cmd_i       (desc_out),
    .pop_o       (pop),
    .busy_o      (busy),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_kind_o  (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

endmodule

`default_nettype wire
